### sv/slfr_pkg.sv
`default_nettype none
package slfr_pkg;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CMD, ST_CMP, ST_SEQ, ST_LEN, ST_OPTS, ST_PTSF, ST_DATA, ST_SUM
   } parse_state_type;

   typedef enum logic [2:0] {
      OP_RX = 3'd0, OP_POP_CMD = 3'd1, OP_TAKE_CTRL = 3'd2,
      OP_READ_PKG = 3'd3, OP_CHECK_OUT = 3'd4
   } opcode_type;

   localparam logic [1:0] RP_NONE = 2'd0;
   localparam logic [1:0] RP_ACK  = 2'd1;
   localparam logic [1:0] RP_NAK  = 2'd2;
   localparam logic [1:0] RP_SYN  = 2'd3;

   localparam logic [7:0] CH_SOH  = 8'h01;
   localparam logic [7:0] CH_ACK  = 8'h06;
   localparam logic [7:0] CH_NAK  = 8'h15;
   localparam logic [7:0] CH_SYN  = 8'h16;
   localparam logic [7:0] CH_HASH = 8'h23;

endpackage
`default_nettype wire

### sv/serial_link_frame_receiver.sv
`default_nettype none
// Channel   Direction  Ports                                   Handshake
// req_      in         opcode, rx_byte, data_index             req_valid / req_ready
// rsp_      out        accepted, reply, flags, read_value,     rsp_valid / rsp_ready
//                      pkg_length, pkg_type, pkg_device, pkg_size_code, pkg_ptsf
//
// One request per cycle while the response side is not stalled; its response is registered and appears the next cycle.
// The parser, ring pointers and flags update in the single accept cycle.
// Package data sits in a memory read with a registered port; that read lands in
// the response, so the response for every opcode appears the cycle after the accept.
// Reset clears parser, flags and ring positions; the stores are not cleared.
// A stalled response holds; req_ready follows rsp_ready or an empty response slot.
module serial_link_frame_receiver
   import slfr_pkg::*;
#(
   parameter int CMD_SLOTS    = 8,
   parameter int PKG_SLOTS    = 4,
   parameter int SYN_INTERVAL = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [2:0] req_opcode,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic [7:0] req_data_index,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_accepted,
   output logic [1:0]      rsp_reply,
   output logic            rsp_cmd_ready,
   output logic            rsp_ctrl_ready,
   output logic            rsp_pkg_ready,
   output logic [7:0]      rsp_read_value,
   output logic [8:0]      rsp_pkg_length,
   output logic [1:0]      rsp_pkg_type,
   output logic [3:0]      rsp_pkg_device,
   output logic [1:0]      rsp_pkg_size_code,
   output logic [7:0]      rsp_pkg_ptsf
);

   localparam int CW = (CMD_SLOTS > 1) ? $clog2(CMD_SLOTS) : 1;
   localparam int PW = (PKG_SLOTS > 1) ? $clog2(PKG_SLOTS) : 1;
   localparam logic [CW-1:0] CMD_LAST = CW'(CMD_SLOTS - 1);
   localparam logic [PW-1:0] PKG_LAST = PW'(PKG_SLOTS - 1);
   localparam logic [8:0] SYN_LAST = 9'(SYN_INTERVAL - 1);

   parse_state_type state_ff, state_in;
   logic [7:0] held_ff, held_in, ctrl_ff, ctrl_in, seq_ff, seq_in, sum_ff, sum_in;
   logic [8:0] cnt_ff, cnt_in, syn_ff, syn_in;
   logic cmdf_ff, cmdf_in, ctrlf_ff, ctrlf_in, pkgf_ff, pkgf_in;
   logic [CW-1:0] cwp_ff, cwp_in, crp_ff, crp_in;
   logic [PW-1:0] pwp_ff, pwp_in, prp_ff, prp_in;

   logic [7:0] cmd_mem [CMD_SLOTS];
   logic [8:0] len_mem [PKG_SLOTS];
   logic [7:0] opt_mem [PKG_SLOTS];
   logic [7:0] ptsf_mem [PKG_SLOTS];
   logic [7:0] data_mem [PKG_SLOTS*256];

   logic fire;
   logic acc_c;
   logic [1:0] rp_c;
   logic [7:0] rv_c;
   logic cmd_we, len_we, opt_we, ptsf_we, data_we;
   logic [8:0] len_val, cnt_inc;
   logic data_rd_sel_ff;
   logic [7:0] data_rd_ff, rv_ff;

   function automatic logic [CW-1:0] cdown(input logic [CW-1:0] p);
      return (p == '0 || {1'b0, p} >= (CW+1)'(CMD_SLOTS)) ? CMD_LAST : p - 1'b1;
   endfunction
   function automatic logic [PW-1:0] pdown(input logic [PW-1:0] p);
      return (p == '0 || {1'b0, p} >= (PW+1)'(PKG_SLOTS)) ? PKG_LAST : p - 1'b1;
   endfunction

   assign req_ready = !rsp_valid || rsp_ready;
   assign fire = req_valid && req_ready;
   assign cnt_inc = cnt_ff + 9'd1;
   assign len_val = (req_rx_byte == 8'd0) ? 9'd256 : {1'b0, req_rx_byte};

   // Parser and consumer step for one request.
   always_comb begin
      state_in = state_ff; held_in = held_ff; ctrl_in = ctrl_ff; seq_in = seq_ff;
      sum_in = sum_ff; cnt_in = cnt_ff; syn_in = syn_ff; cmdf_in = cmdf_ff;
      ctrlf_in = ctrlf_ff; pkgf_in = pkgf_ff; cwp_in = cwp_ff; crp_in = crp_ff;
      pwp_in = pwp_ff; prp_in = prp_ff; acc_c = 1'b0; rp_c = RP_NONE; rv_c = 8'd0;
      cmd_we = 1'b0; len_we = 1'b0; opt_we = 1'b0; ptsf_we = 1'b0; data_we = 1'b0;
      case (opcode_type'(req_opcode))
         OP_RX: begin
            acc_c = 1'b1;
            unique case (state_ff)
               ST_IDLE: begin
                  if (req_rx_byte == CH_HASH) state_in = ST_CMD;
                  else if (req_rx_byte == CH_ACK || req_rx_byte == CH_NAK ||
                           req_rx_byte == CH_SYN) begin
                     ctrl_in = req_rx_byte; ctrlf_in = 1'b1;
                  end else if (req_rx_byte == CH_SOH) state_in = ST_SEQ;
               end
               ST_CMD: begin
                  held_in = req_rx_byte; state_in = ST_CMP;
               end
               ST_CMP: begin
                  if (cmdf_ff && cwp_ff == crp_ff) acc_c = 1'b0;
                  else begin
                     if (~req_rx_byte == held_ff) begin
                        cmd_we = 1'b1; cwp_in = cdown(cwp_ff); cmdf_in = 1'b1;
                        rp_c = RP_ACK;
                     end else rp_c = RP_NAK;
                     state_in = ST_IDLE;
                  end
               end
               ST_SEQ: begin
                  if (pkgf_ff && pwp_ff == prp_ff) acc_c = 1'b0;
                  else if (req_rx_byte != seq_ff) begin
                     rp_c = RP_NAK; state_in = ST_IDLE;
                  end else begin
                     rp_c = RP_SYN; state_in = ST_LEN;
                  end
               end
               ST_LEN: begin
                  len_we = 1'b1; sum_in = sum_ff + req_rx_byte; state_in = ST_OPTS;
               end
               ST_OPTS: begin
                  opt_we = 1'b1; sum_in = sum_ff + req_rx_byte; state_in = ST_PTSF;
               end
               ST_PTSF: begin
                  ptsf_we = 1'b1; sum_in = sum_ff + req_rx_byte; rp_c = RP_SYN;
                  state_in = ST_DATA;
               end
               ST_DATA: begin
                  data_we = 1'b1; cnt_in = cnt_inc; sum_in = sum_ff + req_rx_byte;
                  // Wrap the interval counter; a wrap marks a periodic SYN.
                  syn_in = (syn_ff == SYN_LAST) ? 9'd0 : syn_ff + 9'd1;
                  if (syn_ff == SYN_LAST) rp_c = RP_SYN;
                  if (cnt_inc >= len_mem[pwp_ff]) state_in = ST_SUM;
               end
               ST_SUM: begin
                  if (req_rx_byte == sum_ff) begin
                     pwp_in = pdown(pwp_ff); seq_in = seq_ff + 8'd1; pkgf_in = 1'b1;
                     rp_c = RP_ACK;
                  end else rp_c = RP_NAK;
                  sum_in = 8'd0; cnt_in = 9'd0; syn_in = 9'd0; state_in = ST_IDLE;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         OP_POP_CMD: if (cmdf_ff) begin
            rv_c = cmd_mem[crp_ff]; crp_in = cdown(crp_ff);
            if (cwp_ff == cdown(crp_ff)) cmdf_in = 1'b0;
         end
         OP_TAKE_CTRL: if (ctrlf_ff) begin
            rv_c = ctrl_ff; ctrlf_in = 1'b0;
         end
         OP_CHECK_OUT: if (pkgf_ff) begin
            prp_in = pdown(prp_ff);
            if (pwp_ff == pdown(prp_ff)) pkgf_in = 1'b0;
         end
         default: ;
      endcase
   end

   // Stores: written in the accept cycle.
   always_ff @(posedge clock) begin
      if (fire) begin
         if (cmd_we) cmd_mem[cwp_ff] <= held_ff;
         if (len_we) len_mem[pwp_ff] <= len_val;
         if (opt_we) opt_mem[pwp_ff] <= req_rx_byte;
         if (ptsf_we) ptsf_mem[pwp_ff] <= req_rx_byte;
      end
   end

   // Package data memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (fire && data_we) data_mem[{pwp_ff, cnt_ff[7:0]}] <= req_rx_byte;
      if (fire) data_rd_ff <= data_mem[{prp_ff, req_data_index}];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; held_ff <= '0; ctrl_ff <= '0; seq_ff <= '0;
         sum_ff <= '0; cnt_ff <= '0; syn_ff <= '0; cmdf_ff <= 1'b0; ctrlf_ff <= 1'b0;
         pkgf_ff <= 1'b0; cwp_ff <= CMD_LAST; crp_ff <= CMD_LAST;
         pwp_ff <= PKG_LAST; prp_ff <= PKG_LAST; rsp_valid <= 1'b0;
      end else begin
         if (fire) begin
            state_ff <= state_in; held_ff <= held_in; ctrl_ff <= ctrl_in;
            seq_ff <= seq_in; sum_ff <= sum_in; cnt_ff <= cnt_in; syn_ff <= syn_in;
            cmdf_ff <= cmdf_in; ctrlf_ff <= ctrlf_in; pkgf_ff <= pkgf_in;
            cwp_ff <= cwp_in; crp_ff <= crp_in; pwp_ff <= pwp_in; prp_ff <= prp_in;
            rsp_valid <= 1'b1;
         end else if (rsp_ready) rsp_valid <= 1'b0;
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_accepted <= acc_c;
         rsp_reply <= rp_c;
         rv_ff <= rv_c;
         data_rd_sel_ff <= (opcode_type'(req_opcode) == OP_READ_PKG) && pkgf_ff;
      end
   end

   assign rsp_read_value = data_rd_sel_ff ? data_rd_ff : rv_ff;
   assign rsp_cmd_ready = cmdf_ff;
   assign rsp_ctrl_ready = ctrlf_ff;
   assign rsp_pkg_ready = pkgf_ff;
   assign rsp_pkg_length = pkgf_ff ? len_mem[prp_ff] : 9'd0;
   assign rsp_pkg_type = pkgf_ff ? opt_mem[prp_ff][7:6] : 2'd0;
   assign rsp_pkg_device = pkgf_ff ? opt_mem[prp_ff][5:2] : 4'd0;
   assign rsp_pkg_size_code = pkgf_ff ? opt_mem[prp_ff][1:0] : 2'd0;
   assign rsp_pkg_ptsf = pkgf_ff ? ptsf_mem[prp_ff] : 8'd0;

   a_refuse_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_accepted) |-> rsp_reply == RP_NONE)
      else $error("refused byte carries a reply");
   a_ctrl_take: assert property (@(posedge clock) disable iff (reset)
      (fire && opcode_type'(req_opcode) == OP_TAKE_CTRL) |=> !ctrlf_ff)
      else $error("control flag survived take");
   a_seq_step: assert property (@(posedge clock) disable iff (reset)
      (fire && state_ff == ST_SUM && req_opcode == OP_RX && req_rx_byte == sum_ff)
      |=> pkgf_ff)
      else $error("good package not flagged");

endmodule
`default_nettype wire

### tb/sv/serial_link_frame_receiver_checker.sv
`default_nettype none
module serial_link_frame_receiver_checker
   import slfr_pkg::*;
#(
   parameter int CMD_SLOTS    = 8,
   parameter int PKG_SLOTS    = 4,
   parameter int SYN_INTERVAL = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire logic [2:0] req_opcode,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic [7:0] req_data_index,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic       rsp_accepted,
   input  wire logic [1:0] rsp_reply,
   input  wire logic       rsp_cmd_ready,
   input  wire logic       rsp_ctrl_ready,
   input  wire logic       rsp_pkg_ready,
   input  wire logic [7:0] rsp_read_value,
   input  wire logic [8:0] rsp_pkg_length,
   input  wire logic [1:0] rsp_pkg_type,
   input  wire logic [3:0] rsp_pkg_device,
   input  wire logic [1:0] rsp_pkg_size_code,
   input  wire logic [7:0] rsp_pkg_ptsf,
   output int              fail_count,
   output int              pending,
   output logic            parser_idle,
   output logic [7:0]      next_seq,
   output int              packages_held
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic       accepted;
      logic [1:0] reply;
      logic       cmd_ready;
      logic       ctrl_ready;
      logic       pkg_ready;
      logic [7:0] read_value;
      logic [8:0] pkg_length;
      logic [1:0] pkg_type;
      logic [3:0] pkg_device;
      logic [1:0] pkg_size_code;
      logic [7:0] pkg_ptsf;
   } link_status_type;

   link_status_type status_q[$];
   parse_state_type pstate;
   logic [7:0]      held_cmd, ctrl_char, seq_num, csum;
   logic [8:0]      data_cnt;
   logic            cmd_flag, ctrl_flag, pkg_flag;
   int              cmd_wr, cmd_rd, pkg_wr, pkg_rd, pkg_count;
   logic [7:0]      cmd_mem[CMD_SLOTS];
   logic [7:0]      data_mem[PKG_SLOTS*256];
   logic [8:0]      len_mem[PKG_SLOTS];
   logic [7:0]      opts_mem[PKG_SLOTS];
   logic [7:0]      ptsf_mem[PKG_SLOTS];

   assign pending       = status_q.size();
   assign parser_idle   = (pstate == ST_IDLE);
   assign next_seq      = seq_num;
   assign packages_held = pkg_count;

   function automatic int slot_down(int pos, int slots);
      return (pos == 0) ? slots - 1 : pos - 1;
   endfunction

   function automatic void clear_link();
      pstate = ST_IDLE;
      held_cmd = '0; ctrl_char = '0; seq_num = '0; csum = '0; data_cnt = '0;
      cmd_flag = 0; ctrl_flag = 0; pkg_flag = 0; pkg_count = 0;
      cmd_wr = CMD_SLOTS - 1; cmd_rd = CMD_SLOTS - 1;
      pkg_wr = PKG_SLOTS - 1; pkg_rd = PKG_SLOTS - 1;
   endfunction

   // Advance the byte parser; took drops to 0 when the target ring is full.
   function automatic void parse_byte(input logic [7:0] b, output logic took,
                                      output logic [1:0] rp);
      took = 1;
      rp = RP_NONE;
      case (pstate)
         ST_IDLE: begin
            if (b == CH_HASH) pstate = ST_CMD;
            else if (b == CH_ACK || b == CH_NAK || b == CH_SYN) begin
               ctrl_char = b;
               ctrl_flag = 1;
            end else if (b == CH_SOH) pstate = ST_SEQ;
         end
         ST_CMD: begin
            held_cmd = b;
            pstate = ST_CMP;
         end
         ST_CMP: begin
            if (cmd_flag && cmd_wr == cmd_rd) took = 0;
            else begin
               if ((b ^ held_cmd) == 8'hFF) begin
                  cmd_mem[cmd_wr] = held_cmd;
                  cmd_wr = slot_down(cmd_wr, CMD_SLOTS);
                  cmd_flag = 1;
                  rp = RP_ACK;
               end else rp = RP_NAK;
               pstate = ST_IDLE;
            end
         end
         ST_SEQ: begin
            if (pkg_flag && pkg_wr == pkg_rd) took = 0;
            else if (b != seq_num) begin
               rp = RP_NAK;
               pstate = ST_IDLE;
            end else begin
               rp = RP_SYN;
               pstate = ST_LEN;
            end
         end
         ST_LEN: begin
            len_mem[pkg_wr] = (b == 0) ? 9'd256 : {1'b0, b};
            csum += b;
            pstate = ST_OPTS;
         end
         ST_OPTS: begin
            opts_mem[pkg_wr] = b;
            csum += b;
            pstate = ST_PTSF;
         end
         ST_PTSF: begin
            ptsf_mem[pkg_wr] = b;
            csum += b;
            rp = RP_SYN;
            pstate = ST_DATA;
         end
         ST_DATA: begin
            data_mem[pkg_wr*256 + data_cnt[7:0]] = b;
            data_cnt += 1;
            csum += b;
            if (data_cnt % SYN_INTERVAL == 0) rp = RP_SYN;
            if (data_cnt >= len_mem[pkg_wr]) pstate = ST_SUM;
         end
         ST_SUM: begin
            if (b == csum) begin
               pkg_wr = slot_down(pkg_wr, PKG_SLOTS);
               seq_num += 1;
               pkg_flag = 1;
               pkg_count++;
               rp = RP_ACK;
            end else rp = RP_NAK;
            csum = '0;
            data_cnt = '0;
            pstate = ST_IDLE;
         end
         default: pstate = ST_IDLE;
      endcase
   endfunction

   function automatic link_status_type link_status_after(logic [2:0] op, logic [7:0] b,
                                                         logic [7:0] idx);
      link_status_type s;
      s = '{default: '0};
      case (op)
         OP_RX: parse_byte(b, s.accepted, s.reply);
         OP_POP_CMD:
            if (cmd_flag) begin
               s.read_value = cmd_mem[cmd_rd];
               cmd_rd = slot_down(cmd_rd, CMD_SLOTS);
               if (cmd_wr == cmd_rd) cmd_flag = 0;
            end
         OP_TAKE_CTRL:
            if (ctrl_flag) begin
               s.read_value = ctrl_char;
               ctrl_flag = 0;
            end
         OP_READ_PKG:
            if (pkg_flag) s.read_value = data_mem[pkg_rd*256 + idx];
         OP_CHECK_OUT:
            if (pkg_flag) begin
               pkg_rd = slot_down(pkg_rd, PKG_SLOTS);
               pkg_count--;
               if (pkg_wr == pkg_rd) pkg_flag = 0;
            end
         default: ;
      endcase
      s.cmd_ready  = cmd_flag;
      s.ctrl_ready = ctrl_flag;
      s.pkg_ready  = pkg_flag;
      if (pkg_flag) begin
         s.pkg_length    = len_mem[pkg_rd];
         s.pkg_type      = opts_mem[pkg_rd][7:6];
         s.pkg_device    = opts_mem[pkg_rd][5:2];
         s.pkg_size_code = opts_mem[pkg_rd][1:0];
         s.pkg_ptsf      = ptsf_mem[pkg_rd];
      end
      return s;
   endfunction

   task automatic report_mismatch(string what, logic [8:0] got, logic [8:0] want);
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   task automatic match_field(string what, logic [8:0] got, logic [8:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   initial begin
      fail_count = 0;
      clear_link();
   end

   always @(posedge clock) begin
      link_status_type want;
      if (reset) begin
         clear_link();
         status_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (status_q.size() == 0) report_mismatch("unexpected response", 0, 0);
            else begin
               want = status_q.pop_front();
               match_field("accepted", rsp_accepted, want.accepted);
               match_field("reply", rsp_reply, want.reply);
               match_field("cmd_ready", rsp_cmd_ready, want.cmd_ready);
               match_field("ctrl_ready", rsp_ctrl_ready, want.ctrl_ready);
               match_field("pkg_ready", rsp_pkg_ready, want.pkg_ready);
               match_field("read_value", rsp_read_value, want.read_value);
               match_field("pkg_length", rsp_pkg_length, want.pkg_length);
               match_field("pkg_type", rsp_pkg_type, want.pkg_type);
               match_field("pkg_device", rsp_pkg_device, want.pkg_device);
               match_field("pkg_size_code", rsp_pkg_size_code, want.pkg_size_code);
               match_field("pkg_ptsf", rsp_pkg_ptsf, want.pkg_ptsf);
            end
         end
         if (req_valid && req_ready)
            status_q.push_back(link_status_after(req_opcode, req_rx_byte, req_data_index));
      end
   end

endmodule
`default_nettype wire

### tb/sv/serial_link_frame_receiver_tb.sv
`default_nettype none
module serial_link_frame_receiver_tb;
   import slfr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PKG_SLOTS = 4;
   localparam int CMD_SLOTS = 8;
   // Random package reads stay below this index, which every slot has seen written.
   localparam int READ_SPAN = 12;
   // Opcodes past the defined set act as no operation.
   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic [2:0] req_opcode = OP_RX;
   logic [7:0] req_rx_byte = '0;
   logic [7:0] req_data_index = '0;
   logic       rsp_ready = 0;
   logic       req_ready, rsp_valid, rsp_accepted, rsp_cmd_ready, rsp_ctrl_ready;
   logic       rsp_pkg_ready;
   logic [1:0] rsp_reply, rsp_pkg_type, rsp_pkg_size_code;
   logic [7:0] rsp_read_value, rsp_pkg_ptsf;
   logic [8:0] rsp_pkg_length;
   logic [3:0] rsp_pkg_device;

   int         fail_count, pending, packages_held;
   logic       parser_idle;
   logic [7:0] next_seq;

   // When set, neither side idles.
   bit         quiet = 0;
   int         requests = 0;

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   serial_link_frame_receiver dut (.*);

   serial_link_frame_receiver_checker #(
      .CMD_SLOTS(CMD_SLOTS), .PKG_SLOTS(PKG_SLOTS), .SYN_INTERVAL(64)
   ) scoreboard (.*);

   // Stall the response side about one cycle in ten while quiet is clear.
   always @(posedge clock) begin
      rsp_ready <= quiet || ($urandom_range(99) >= 10);
   end

   // Present one request, hold it until the handshake completes.
   task automatic send(logic [2:0] op, logic [7:0] b, logic [7:0] idx);
      while (!quiet && $urandom_range(99) < 10) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid      <= 1;
      req_opcode     <= op;
      req_rx_byte    <= b;
      req_data_index <= idx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests++;
   endtask

   task automatic rx(logic [7:0] b);
      send(OP_RX, b, 8'($urandom));
   endtask

   task automatic consume(logic [2:0] op);
      send(op, 8'($urandom),
           (op == OP_READ_PKG) ? 8'($urandom_range(READ_SPAN - 1)) : 8'($urandom));
   endtask

   // Drain, then bring the parser back to waiting for a control character.
   task automatic sync_idle();
      req_valid <= 0;
      forever begin
         do @(negedge clock); while (pending != 0);
         if (parser_idle) break;
         @(posedge clock);
         rx(8'h00);
         consume(OP_POP_CMD);
         consume(OP_CHECK_OUT);
         req_valid <= 0;
      end
      @(posedge clock);
   endtask

   task automatic send_package(logic [7:0] len_byte, bit bad_seq, bit bad_sum);
      logic [7:0] seq, opts, ptsf, sum, b;
      int         n;
      sync_idle();
      seq  = next_seq;
      opts = 8'($urandom);
      ptsf = 8'($urandom);
      n    = (len_byte == 0) ? 256 : len_byte;
      sum  = len_byte + opts + ptsf;
      rx(CH_SOH);
      if (bad_seq) begin
         rx(seq + 8'($urandom_range(1, 255)));
         return;
      end
      rx(seq);
      rx(len_byte);
      rx(opts);
      rx(ptsf);
      for (int i = 0; i < n; i++) begin
         b = 8'($urandom);
         sum += b;
         rx(b);
      end
      rx(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
   endtask

   task automatic send_command(logic [7:0] cmd, bit good);
      sync_idle();
      rx(CH_HASH);
      rx(cmd);
      rx(good ? ~cmd : ~cmd ^ 8'($urandom_range(1, 255)));
   endtask

   initial begin
      int first, pick;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Fill the oldest slot with a full-length package and the others with
      // READ_SPAN bytes, so every later read hits written storage; the fifth
      // header then meets a full ring.
      send_package(8'h00, 0, 0);
      for (int k = 1; k < PKG_SLOTS; k++) send_package(8'(READ_SPAN), 0, 0);
      send(OP_READ_PKG, 8'h00, 8'hFF);
      send(OP_READ_PKG, 8'hFF, 8'h00);
      sync_idle();
      rx(CH_SOH);
      rx(next_seq);
      for (int k = 0; k < PKG_SLOTS; k++) consume(OP_CHECK_OUT);

      // Empty ring accesses and spare opcodes.
      consume(OP_POP_CMD);
      consume(OP_TAKE_CTRL);
      consume(OP_READ_PKG);
      consume(OP_CHECK_OUT);
      for (logic [3:0] op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++) consume(op[2:0]);

      // Control characters and an unknown byte while waiting.
      rx(CH_ACK);
      rx(CH_NAK);
      rx(CH_SYN);
      consume(OP_TAKE_CTRL);
      rx(8'hFF);

      // Commands at the byte extremes, a bad complement, then a full ring.
      send_command(8'h00, 1);
      send_command(8'hFF, 1);
      send_command(8'h5A, 0);
      for (int k = 0; k < CMD_SLOTS - 2; k++) send_command(8'($urandom), 1);
      send_command(8'hA5, 1);
      for (int k = 0; k < CMD_SLOTS + 1; k++) consume(OP_POP_CMD);

      // Bad sequence, bad checksum, the shortest length and the largest nonzero length byte.
      send_package(8'h03, 1, 0);
      send_package(8'h04, 0, 1);
      send_package(8'h01, 0, 0);
      send_package(8'hFF, 0, 0);
      send(OP_READ_PKG, 8'h00, 8'h00);
      consume(OP_CHECK_OUT);
      consume(OP_CHECK_OUT);

      // Random traffic: mostly well-formed frames with random content.
      first = requests;
      while (requests - first < 400) begin
         quiet = (requests - first >= 150) && (requests - first < 250);
         pick = $urandom_range(99);
         if (pick < 35) begin
            if (packages_held == PKG_SLOTS && $urandom_range(1)) consume(OP_CHECK_OUT);
            send_package($urandom_range(19) == 0 ? 8'($urandom) : 8'($urandom_range(1, 12)),
                         $urandom_range(19) == 0, $urandom_range(9) == 0);
         end else if (pick < 55) send_command(8'($urandom), $urandom_range(9) != 0);
         else if (pick < 62) begin
            case ($urandom_range(2))
               0: rx(CH_ACK);
               1: rx(CH_NAK);
               default: rx(CH_SYN);
            endcase
         end else if (pick < 95) consume(3'($urandom_range(OP_POP_CMD, OP_SPARE_LAST)));
         else rx(8'($urandom));
      end
      quiet = 0;
      req_valid <= 0;

      do @(posedge clock); while (pending != 0);
      repeat (10) @(posedge clock);
      if (fail_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   // Abort a hung run.
   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
`default_nettype wire

### sim.f
sv/slfr_pkg.sv
sv/serial_link_frame_receiver.sv
tb/sv/serial_link_frame_receiver_checker.sv
tb/sv/serial_link_frame_receiver_tb.sv
